### rtl/knn_pkg.sv
// shared types, codes and defaults of the nearest neighbor search block
package knn_pkg;

  localparam int unsigned MaxPointsDef    = 256;
  localparam int unsigned MaxNeighborsDef = 32;

  localparam int unsigned CoordW = 16;
  localparam int unsigned NumDims = 4;
  localparam int unsigned PointW = CoordW * NumDims;
  localparam int unsigned DistW = 34;
  localparam int unsigned CfgW = 6;

  localparam logic [5:0] NeighborCountRst = 6'd8;
  localparam logic [2:0] DimsInUseRst     = 3'd3;

  typedef enum logic [1:0] {
    KindLoad  = 2'd0,
    KindQuery = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StatNeighbor = 3'd0,
    StatLoaded   = 3'd1,
    StatFull     = 3'd2,
    StatNone     = 3'd3,
    StatCleared  = 3'd4
  } status_e;

  typedef enum logic {
    CfgNeighborCount = 1'b0,
    CfgDimsInUse     = 1'b1
  } cfg_idx_e;

  // controls broadcast to every cell of the sorting chain
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

### rtl/knn_if.sv
// request and result channel interfaces of the nearest neighbor search block
interface knn_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         query_index;
  logic signed [15:0] coord_0;
  logic signed [15:0] coord_1;
  logic signed [15:0] coord_2;
  logic signed [15:0] coord_3;

  modport source (output valid, kind, query_index, coord_0, coord_1, coord_2, coord_3,
                  input ready);
  modport sink   (input valid, kind, query_index, coord_0, coord_1, coord_2, coord_3,
                  output ready);
endinterface

interface knn_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  neighbor_index;
  logic [33:0] distance_squared;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, neighbor_index, distance_squared, status, last,
                  input ready);
  modport sink   (input valid, neighbor_index, distance_squared, status, last,
                  output ready);
endinterface

### rtl/knn_ram.sv
// generic single write, single read ram with registered read data
module knn_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/knn_dist.sv
// four stage squared euclidean distance pipeline
module knn_dist #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic [knn_pkg::PointW-1:0] point_i,
  input  logic [knn_pkg::PointW-1:0] query_i,
  input  logic [2:0]                dims_i,
  output logic                      valid_o,
  output logic [IDX_W-1:0]          idx_o,
  output logic [knn_pkg::DistW-1:0] dist_o
);
  import knn_pkg::*;

  logic [3:0]        v_q;
  logic [IDX_W-1:0]  idx_q [4];
  logic [15:0]       ad_d [NumDims];
  logic [15:0]       ad_q [NumDims];
  logic [31:0]       sq_q [NumDims];
  logic [32:0]       pair_q [2];
  logic [DistW-1:0]  dist_q;

  // absolute coordinate difference, unused dimensions forced to zero
  always_comb begin
    logic signed [16:0] diff;
    for (int j = 0; j < NumDims; j++) begin
      diff = 17'(signed'(point_i[j*CoordW +: CoordW]))
           - 17'(signed'(query_i[j*CoordW +: CoordW]));
      if (3'(j) < dims_i) begin
        ad_d[j] = diff[16] ? 16'(-diff) : diff[15:0];
      end else begin
        ad_d[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q[0] <= idx_i;
    for (int s = 1; s < 4; s++) begin
      idx_q[s] <= idx_q[s-1];
    end
    for (int j = 0; j < NumDims; j++) begin
      ad_q[j] <= ad_d[j];
      sq_q[j] <= ad_q[j] * ad_q[j];
    end
    pair_q[0] <= 33'(sq_q[0]) + 33'(sq_q[1]);
    pair_q[1] <= 33'(sq_q[2]) + 33'(sq_q[3]);
    dist_q    <= DistW'(pair_q[0]) + DistW'(pair_q[1]);
  end

  assign valid_o = v_q[3];
  assign idx_o   = idx_q[3];
  assign dist_o  = dist_q;

endmodule

### rtl/knn_cell.sv
// one cell of the systolic insertion sorter holding one candidate
module knn_cell #(
  parameter int unsigned IDX_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  knn_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       in_v_i,
  input  logic [knn_pkg::DistW-1:0]  in_dist_i,
  input  logic [IDX_W-1:0]           in_idx_i,
  input  logic                       nxt_v_i,
  input  logic [knn_pkg::DistW-1:0]  nxt_dist_i,
  input  logic [IDX_W-1:0]           nxt_idx_i,
  output logic                       pass_v_o,
  output logic [knn_pkg::DistW-1:0]  pass_dist_o,
  output logic [IDX_W-1:0]           pass_idx_o,
  output logic                       held_v_o,
  output logic [knn_pkg::DistW-1:0]  held_dist_o,
  output logic [IDX_W-1:0]           held_idx_o
);
  import knn_pkg::*;

  logic             held_v_q, pass_v_q;
  logic [DistW-1:0] held_dist_q, pass_dist_q;
  logic [IDX_W-1:0] held_idx_q, pass_idx_q;
  logic             take;

  // smaller distance wins, on equal distance the lower store index wins,
  // so the chain order does not depend on the order candidates arrive in
  assign take = !held_v_q || (in_dist_i < held_dist_q) ||
                ((in_dist_i == held_dist_q) && (in_idx_i < held_idx_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
      pass_v_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      held_v_q <= 1'b0;
      pass_v_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      held_v_q <= nxt_v_i;
      pass_v_q <= 1'b0;
    end else if (in_v_i) begin
      if (take) begin
        held_v_q <= 1'b1;
        pass_v_q <= held_v_q;
      end else begin
        pass_v_q <= 1'b1;
      end
    end else begin
      pass_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      held_dist_q <= nxt_dist_i;
      held_idx_q  <= nxt_idx_i;
    end else if (in_v_i && take) begin
      held_dist_q <= in_dist_i;
      held_idx_q  <= in_idx_i;
      pass_dist_q <= held_dist_q;
      pass_idx_q  <= held_idx_q;
    end else if (in_v_i) begin
      pass_dist_q <= in_dist_i;
      pass_idx_q  <= in_idx_i;
    end
  end

  assign pass_v_o    = pass_v_q;
  assign pass_dist_o = pass_dist_q;
  assign pass_idx_o  = pass_idx_q;
  assign held_v_o    = held_v_q;
  assign held_dist_o = held_dist_q;
  assign held_idx_o  = held_idx_q;

endmodule

### rtl/k_nearest_neighbor_search_top.sv
// top level of the brute force k nearest neighbor search block
//
// requests arrive on req_i: kind load stores a point at the next free index,
// kind query asks for the neighbors of a stored point, kind clear empties the
// store. results leave on rsp_o, one per load or clear, and for a query either
// min(k, points - 1) neighbors, nearest first, or a single no-neighbor result.
// last marks the final result of each request.
// load and clear results are registered; the next request is taken as soon as the
// result register is free or being emptied in the same cycle.
// a query walks the point ram once at one point per cycle, then emits one
// neighbor per cycle while rsp_o is ready. the ram read port and the length of
// the sorting chain set the wait before the first neighbor.
// a query holds off new requests until its last neighbor is in the output
// register; a stalled receiver simply stalls the emit sequence.
// reset empties the store and sets k to 8 and the dimension count to 3;
// stored coordinates are not erased, and need no clearing pass. the user
// writes configuration on cfg_we_i while the block is idle; it is not enforced.
module k_nearest_neighbor_search_top #(
  parameter int unsigned MAX_POINTS    = knn_pkg::MaxPointsDef,
  parameter int unsigned MAX_NEIGHBORS = knn_pkg::MaxNeighborsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  knn_req_if.sink                 req_i,
  knn_rsp_if.source               rsp_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [knn_pkg::CfgW-1:0] cfg_data_i
);
  import knn_pkg::*;

  localparam int unsigned PW      = $clog2(MAX_POINTS);
  localparam int unsigned TW      = PW + 1;
  localparam int unsigned NW      = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned IdxExtW = (PW > 8) ? PW : 8;
  localparam int unsigned CmpW    = ((IdxExtW + 1) > NW) ? (IdxExtW + 1) : NW;
  localparam int unsigned KCmpW   = (NW > 7) ? NW : 7;
  // ram read, distance pipeline and a walk down the whole chain, with margin
  localparam int unsigned FlushCycles = MAX_NEIGHBORS + 8;
  localparam int unsigned FW      = $clog2(FlushCycles + 1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StQread = 5'b00010,
    StScan  = 5'b00100,
    StFlush = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [5:0] neighbor_count_q;
  logic [2:0] dims_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neighbor_count_q <= NeighborCountRst;
      dims_in_use_q    <= DimsInUseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNeighborCount: neighbor_count_q <= cfg_data_i[5:0];
        CfgDimsInUse:     dims_in_use_q    <= cfg_data_i[2:0];
        default:          ;
      endcase
    end
  end

  // effective k and dimension count, clamped into their legal ranges
  logic [NW-1:0] k_eff;
  logic [2:0]    dims_eff;

  always_comb begin
    if (neighbor_count_q == '0) begin
      k_eff = NW'(1);
    end else if (KCmpW'(neighbor_count_q) > KCmpW'(MAX_NEIGHBORS)) begin
      k_eff = NW'(MAX_NEIGHBORS);
    end else begin
      k_eff = NW'(neighbor_count_q);
    end
    if (dims_in_use_q == '0) begin
      dims_eff = 3'd1;
    end else if (dims_in_use_q > 3'd4) begin
      dims_eff = 3'd4;
    end else begin
      dims_eff = dims_in_use_q;
    end
  end

  // request decode
  logic               out_v_q;
  logic               out_free;
  logic               req_fire;
  logic [TW-1:0]      total_q;
  logic [IdxExtW-1:0] q_ext;
  logic               q_bad;
  logic [TW-1:0]      others;
  logic [NW-1:0]      count_d;

  assign out_free    = !out_v_q || rsp_o.ready;
  assign req_i.ready = (state_q == StIdle) && out_free;
  assign req_fire    = req_i.valid && req_i.ready;

  assign q_ext  = IdxExtW'(req_i.query_index);
  assign q_bad  = (CmpW'(q_ext) >= CmpW'(total_q)) || (total_q < TW'(2));
  assign others = total_q - TW'(1);
  assign count_d = (CmpW'(k_eff) < CmpW'(others)) ? k_eff : NW'(others);

  // query bookkeeping
  logic [PW-1:0]     qidx_q;
  logic [PW-1:0]     scan_q;
  logic [FW-1:0]     flush_q;
  logic [NW-1:0]     count_q;
  logic [NW-1:0]     emit_q;
  logic [2:0]        dims_q;
  logic [PointW-1:0] qpoint_q;
  logic              rv_q;
  logic [PW-1:0]     ridx_q;
  logic              emit_load;
  logic              emit_last;
  logic              scan_end;

  assign scan_end  = (TW'(scan_q) == others);
  assign emit_load = (state_q == StEmit) && out_free;
  assign emit_last = (emit_q == count_q - NW'(1));

  // point store
  logic              ram_we;
  logic [PW-1:0]     ram_raddr;
  logic [PointW-1:0] ram_rdata;

  assign ram_we    = req_fire && (req_i.kind == KindLoad) && (total_q < TW'(MAX_POINTS));
  assign ram_raddr = (state_q == StScan) ? scan_q : q_ext[PW-1:0];

  knn_ram #(
    .WIDTH (PointW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (total_q[PW-1:0]),
    .wdata_i ({req_i.coord_3, req_i.coord_2, req_i.coord_1, req_i.coord_0}),
    .re_i    (1'b1),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // distance pipeline, the query point itself is skipped
  logic             dv;
  logic [PW-1:0]    didx;
  logic [DistW-1:0] ddist;

  knn_dist #(
    .IDX_W (PW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q && (ridx_q != qidx_q)),
    .idx_i   (ridx_q),
    .point_i (ram_rdata),
    .query_i (qpoint_q),
    .dims_i  (dims_q),
    .valid_o (dv),
    .idx_o   (didx),
    .dist_o  (ddist)
  );

  // sorting chain: each cell keeps the smaller candidate and passes the other
  cell_ctrl_t       cell_ctrl;
  logic             c_pv [MAX_NEIGHBORS];
  logic [DistW-1:0] c_pd [MAX_NEIGHBORS];
  logic [PW-1:0]    c_pi [MAX_NEIGHBORS];
  logic             c_hv [MAX_NEIGHBORS];
  logic [DistW-1:0] c_hd [MAX_NEIGHBORS];
  logic [PW-1:0]    c_hi [MAX_NEIGHBORS];

  assign cell_ctrl.clear = (state_q == StQread);
  assign cell_ctrl.shift = emit_load;

  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
    logic             in_v, nx_v;
    logic [DistW-1:0] in_d, nx_d;
    logic [PW-1:0]    in_i, nx_i;

    if (g == 0) begin : g_head
      assign in_v = dv;
      assign in_d = ddist;
      assign in_i = didx;
    end else begin : g_body
      assign in_v = c_pv[g-1];
      assign in_d = c_pd[g-1];
      assign in_i = c_pi[g-1];
    end

    if (g == MAX_NEIGHBORS - 1) begin : g_tail
      assign nx_v = 1'b0;
      assign nx_d = '0;
      assign nx_i = '0;
    end else begin : g_link
      assign nx_v = c_hv[g+1];
      assign nx_d = c_hd[g+1];
      assign nx_i = c_hi[g+1];
    end

    knn_cell #(
      .IDX_W (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .in_v_i      (in_v),
      .in_dist_i   (in_d),
      .in_idx_i    (in_i),
      .nxt_v_i     (nx_v),
      .nxt_dist_i  (nx_d),
      .nxt_idx_i   (nx_i),
      .pass_v_o    (c_pv[g]),
      .pass_dist_o (c_pd[g]),
      .pass_idx_o  (c_pi[g]),
      .held_v_o    (c_hv[g]),
      .held_dist_o (c_hd[g]),
      .held_idx_o  (c_hi[g])
    );
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_fire && (req_i.kind == KindQuery) && !q_bad) begin
          state_d = StQread;
        end
      end
      StQread: state_d = StScan;
      StScan: begin
        if (scan_end) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (flush_q == FW'(FlushCycles)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit_load && emit_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      total_q <= '0;
      scan_q  <= '0;
      flush_q <= '0;
      emit_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == StScan);
      if (ram_we) begin
        total_q <= total_q + TW'(1);
      end else if (req_fire && (req_i.kind == KindClear)) begin
        total_q <= '0;
      end
      scan_q  <= (state_q == StScan) ? scan_q + PW'(1) : '0;
      flush_q <= (state_q == StFlush) ? flush_q + FW'(1) : '0;
      if (state_q != StEmit) begin
        emit_q <= '0;
      end else if (emit_load) begin
        emit_q <= emit_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= scan_q;
    if (req_fire) begin
      qidx_q  <= q_ext[PW-1:0];
      count_q <= count_d;
      dims_q  <= dims_eff;
    end
    if (state_q == StQread) begin
      qpoint_q <= ram_rdata;
    end
  end

  // result register
  logic               out_load;
  logic [7:0]         out_idx_d, out_idx_q;
  logic [DistW-1:0]   out_dist_d, out_dist_q;
  status_e            out_stat_d, out_stat_q;
  logic               out_last_d, out_last_q;
  logic [IdxExtW-1:0] emit_idx_ext;

  assign emit_idx_ext = IdxExtW'(c_hi[0]);

  always_comb begin
    out_load   = 1'b0;
    out_idx_d  = '0;
    out_dist_d = '0;
    out_stat_d = StatNone;
    out_last_d = 1'b1;
    if (emit_load) begin
      out_load   = 1'b1;
      out_idx_d  = emit_idx_ext[7:0];
      out_dist_d = c_hd[0];
      out_stat_d = StatNeighbor;
      out_last_d = emit_last;
    end else if (req_fire) begin
      case (req_i.kind)
        KindLoad: begin
          out_load   = 1'b1;
          out_stat_d = (total_q < TW'(MAX_POINTS)) ? StatLoaded : StatFull;
        end
        KindQuery: begin
          out_load   = q_bad;
          out_stat_d = StatNone;
        end
        KindClear: begin
          out_load   = 1'b1;
          out_stat_d = StatCleared;
        end
        default: out_load = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= out_idx_d;
      out_dist_q <= out_dist_d;
      out_stat_q <= out_stat_d;
      out_last_q <= out_last_d;
    end
  end

  assign rsp_o.valid            = out_v_q;
  assign rsp_o.neighbor_index   = out_idx_q;
  assign rsp_o.distance_squared = out_dist_q;
  assign rsp_o.status           = out_stat_q;
  assign rsp_o.last             = out_last_q;

  // the chain head always holds a real candidate while neighbors are emitted
  a_emit_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |-> c_hv[0])
    else $error("emitting from an empty chain cell");

  // a query walk only starts with at least two stored points
  a_scan_has_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (total_q >= TW'(2)))
    else $error("scan with fewer than two points");

  // the emit counter never runs past the neighbor count
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (emit_q < count_q))
    else $error("emit counter overran neighbor count");

  // store fill never exceeds its depth
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(MAX_POINTS))
    else $error("point count beyond store depth");

  // no new request slips in while a query is in flight
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !req_i.ready)
    else $error("request accepted during a query");

endmodule

### test/k_nearest_neighbor_search_top_test.sv
// self-checking testbench for the k nearest neighbor search block
module k_nearest_neighbor_search_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import knn_pkg::*;

  localparam int unsigned MaxPoints    = MaxPointsDef;
  localparam int unsigned MaxNeighbors = MaxNeighborsDef;
  // kind code the block must ignore without any result
  localparam logic [1:0]  KindUnused   = 2'd3;
  // one full query walk plus the sorting chain, with some margin
  localparam int unsigned SettleCycles = MaxPoints + MaxNeighbors + 16;
  localparam int unsigned RandomItems  = 16;
  // slowest legal run: ~400 requests, each with a full-store walk, 32 neighbors
  // and a receiver stall before each neighbor; the limit sits several times
  // above what that run takes
  localparam int unsigned RunLimitNs   = 5_000_000;

  // how coordinates of random points are spread
  typedef enum int unsigned {
    SpreadWide,
    SpreadTight,
    SpreadEdge
  } spread_e;

  typedef struct packed {
    logic [1:0]                      kind;
    logic [7:0]                      query_index;
    logic [NumDims-1:0][CoordW-1:0]  coord;
  } knn_req_t;

  typedef struct packed {
    logic [7:0]       neighbor_index;
    logic [DistW-1:0] distance_squared;
    status_e          status;
    logic             last;
  } search_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [CfgW-1:0] cfg_data;

  knn_req_if req ();
  knn_rsp_if rsp ();

  k_nearest_neighbor_search_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // mirror of the block state, updated when a request is accepted
  logic [CoordW-1:0] store_coords [MaxPoints][NumDims];
  int unsigned       stored_count;
  logic [5:0]        k_setting;
  logic [2:0]        dims_setting;

  search_result_t results_due [$];

  // idling controls of the request driver and the result receiver
  bit          send_gaps_on;
  bit          recv_stalls_on;
  int unsigned hold_off_cycles;

  int unsigned error_count;
  int unsigned results_checked;
  int unsigned loads_sent, queries_sent, clears_sent, ignored_sent;
  int unsigned settings_tried;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(RunLimitNs);
    $display("timeout waiting for results, %0d still pending", results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_result(int unsigned idx, longint unsigned dsq,
                                       status_e st, logic is_last);
    search_result_t res;
    res.neighbor_index   = idx[7:0];
    res.distance_squared = dsq[DistW-1:0];
    res.status           = st;
    res.last             = is_last;
    results_due.insert(results_due.size(), res);
  endfunction

  // works out the results of one accepted request and updates the mirror
  function automatic void forecast_results(knn_req_t r);
    longint unsigned best_dsq [MaxNeighbors];
    int unsigned     best_idx [MaxNeighbors];
    longint unsigned dsq, mag;
    int              diff;
    int unsigned     k, dims, found, pos, q;

    case (r.kind)
      KindLoad: begin
        if (stored_count < MaxPoints) begin
          for (int c = 0; c < NumDims; c++) store_coords[stored_count][c] = r.coord[c];
          stored_count++;
          queue_result(0, 0, StatLoaded, 1'b1);
        end else begin
          queue_result(0, 0, StatFull, 1'b1);
        end
      end
      KindClear: begin
        // coordinates stay, only the count goes
        stored_count = 0;
        queue_result(0, 0, StatCleared, 1'b1);
      end
      KindQuery: begin
        q = r.query_index;
        if (q >= stored_count || stored_count < 2) begin
          queue_result(0, 0, StatNone, 1'b1);
        end else begin
          k    = (k_setting == 0) ? 1 : (k_setting > MaxNeighbors) ? MaxNeighbors : k_setting;
          dims = (dims_setting == 0) ? 1 : (dims_setting > NumDims) ? NumDims : dims_setting;
          found = 0;
          for (int unsigned i = 0; i < stored_count; i++) begin
            if (i == q) continue;
            dsq = 0;
            for (int unsigned c = 0; c < dims; c++) begin
              diff = int'($signed(store_coords[q][c])) - int'($signed(store_coords[i][c]));
              mag  = (diff < 0) ? -diff : diff;
              dsq += mag * mag;
            end
            if (found == k && dsq >= best_dsq[found-1]) continue;
            // shift only past strictly larger distances so earlier indices win ties
            pos = (found < k) ? found : k - 1;
            while (pos > 0 && best_dsq[pos-1] > dsq) begin
              best_dsq[pos] = best_dsq[pos-1];
              best_idx[pos] = best_idx[pos-1];
              pos--;
            end
            best_dsq[pos] = dsq;
            best_idx[pos] = i;
            if (found < k) found++;
          end
          for (int unsigned n = 0; n < found; n++)
            queue_result(best_idx[n], best_dsq[n], StatNeighbor, n + 1 == found);
        end
      end
      default: ;  // unused kind: nothing happens
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  function automatic logic [CoordW-1:0] rand_coord(spread_e s);
    case (s)
      SpreadTight: return CoordW'($urandom_range(0, 8) - 4);
      SpreadEdge: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return CoordW'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // request with random payload in every field, kind set by the caller
  function automatic knn_req_t plain_req(logic [1:0] kind);
    knn_req_t r;
    r.kind        = kind;
    r.query_index = 8'($urandom_range(0, 255));
    for (int c = 0; c < NumDims; c++) r.coord[c] = rand_coord(SpreadWide);
    return r;
  endfunction

  function automatic knn_req_t load_req(logic [CoordW-1:0] c0, logic [CoordW-1:0] c1,
                                        logic [CoordW-1:0] c2, logic [CoordW-1:0] c3);
    knn_req_t r;
    r          = plain_req(KindLoad);
    r.coord[0] = c0;
    r.coord[1] = c1;
    r.coord[2] = c2;
    r.coord[3] = c3;
    return r;
  endfunction

  function automatic knn_req_t random_load(spread_e s);
    return load_req(rand_coord(s), rand_coord(s), rand_coord(s), rand_coord(s));
  endfunction

  function automatic knn_req_t query_req(int unsigned q);
    knn_req_t r;
    r             = plain_req(KindQuery);
    r.query_index = q[7:0];
    return r;
  endfunction

  // mostly a stored point, now and then any index at all
  function automatic int unsigned pick_query_index();
    if (stored_count == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, stored_count - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // offers one request and returns at the edge where it is accepted;
  // valid is left high so that back-to-back requests need a single update
  task automatic issue_request(knn_req_t r);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= r.kind;
    req.query_index <= r.query_index;
    req.coord_0     <= r.coord[0];
    req.coord_1     <= r.coord[1];
    req.coord_2     <= r.coord[2];
    req.coord_3     <= r.coord[3];
    do @(posedge clk); while (req.ready !== 1'b1);
    forecast_results(r);
    case (r.kind)
      KindLoad:  loads_sent++;
      KindQuery: queries_sent++;
      KindClear: clears_sent++;
      default:   ignored_sent++;
    endcase
  endtask

  // stop offering requests and wait for every pending result
  task automatic drain_results();
    req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // drain, then wait for a full query walk and the sorting chain to settle
  task automatic quiesce();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_setting(cfg_idx_e idx, logic [CfgW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgNeighborCount) k_setting = value;
    else dims_setting = value[2:0];
    settings_tried++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver and checker
  // ---------------------------------------------------------------------------

  // ready with random stall bursts; a long hold-off is counted here on request
  initial begin : result_ready
    int unsigned n;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
      end
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    search_result_t want;
    if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      results_checked++;
      if (results_due.size() == 0) begin
        flag_error($sformatf("unexpected result: idx %0d dsq %0d status %0d last %0b",
                             rsp.neighbor_index, rsp.distance_squared, rsp.status,
                             rsp.last));
      end else begin
        want = results_due.pop_front();
        if (rsp.neighbor_index !== want.neighbor_index ||
            rsp.distance_squared !== want.distance_squared ||
            rsp.status !== want.status || rsp.last !== want.last) begin
          flag_error($sformatf({"result %0d mismatch: expected idx %0d dsq %0d status %0d",
                                " last %0b, got idx %0d dsq %0d status %0d last %0b"},
                               results_checked, want.neighbor_index,
                               want.distance_squared, want.status, want.last,
                               rsp.neighbor_index, rsp.distance_squared, rsp.status,
                               rsp.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults, empty and lonely store, invalid index, ties, extreme values
  task automatic test_directed_basics();
    issue_request(query_req(0));                  // empty store
    issue_request(plain_req(KindUnused));         // ignored
    issue_request(plain_req(KindClear));
    issue_request(load_req(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    issue_request(query_req(0));                  // only one point stored
    issue_request(query_req(255));                // far past the store
    issue_request(load_req(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    issue_request(load_req(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    issue_request(load_req(16'h0000, 16'h0000, 16'h0000, 16'h0000));  // duplicate
    issue_request(load_req(16'h0001, 16'hffff, 16'h0001, 16'hffff));
    for (int unsigned q = 0; q < 5; q++) issue_request(query_req(q));
    issue_request(query_req(5));                  // index equal to the count
    // single neighbor over all four coordinates: full-scale distance and tie order
    quiesce();
    write_setting(CfgNeighborCount, 6'd1);
    write_setting(CfgDimsInUse, 6'd4);
    issue_request(query_req(0));
    issue_request(query_req(2));
    issue_request(query_req(4));                  // two points at equal distance
  endtask

  // out-of-range and boundary register values on a store with many ties
  task automatic test_config_extremes();
    logic [CfgW-1:0] k_picks [7]    = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63, 6'd40, 6'd8};
    logic [CfgW-1:0] dims_picks [7] = '{6'd0, 6'd1, 6'd4, 6'd5, 6'd7, 6'b111010, 6'd3};
    issue_request(plain_req(KindClear));
    repeat (10) issue_request(random_load(SpreadTight));
    for (int i = 0; i < 7; i++) begin
      quiesce();
      write_setting(CfgNeighborCount, k_picks[i]);
      write_setting(CfgDimsInUse, dims_picks[i]);
      issue_request(query_req(0));
      issue_request(query_req(pick_query_index()));
    end
  endtask

  // fill the whole store, overflow it, and search the full store
  task automatic test_store_full();
    issue_request(plain_req(KindClear));
    repeat (MaxPoints) issue_request(random_load(spread_e'($urandom_range(0, 2))));
    issue_request(random_load(SpreadWide));       // dropped
    issue_request(random_load(SpreadEdge));       // dropped
    quiesce();
    write_setting(CfgNeighborCount, 6'd32);
    write_setting(CfgDimsInUse, 6'd4);
    issue_request(query_req(0));
    issue_request(query_req(128));
    issue_request(query_req(MaxPoints - 1));
    issue_request(plain_req(KindClear));
    issue_request(query_req(0));                  // store empty again
  endtask

  // receiver holds off for a long stretch while requests keep coming, then the
  // sender pauses until every result is in; four queries with idling follow
  task automatic test_backpressure();
    quiesce();
    write_setting(CfgNeighborCount, 6'd5);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_off_cycles = 400;
    issue_request(plain_req(KindClear));
    repeat (8) issue_request(random_load(SpreadWide));
    issue_request(query_req(3));
    issue_request(plain_req(KindUnused));
    issue_request(query_req(pick_query_index()));
    repeat (4) issue_request(random_load(SpreadTight));
    drain_results();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    repeat (4) issue_request(query_req(pick_query_index()));
  endtask

  // phases of clear, loads and queries with random settings and idling
  task automatic test_random_sequences();
    int unsigned sent, n_pts, n_q;
    spread_e     s;
    sent = 0;
    while (sent < RandomItems) begin
      quiesce();
      if ($urandom_range(0, 2) == 0) write_setting(CfgNeighborCount, CfgW'($urandom_range(0, 63)));
      if ($urandom_range(0, 2) == 0) write_setting(CfgDimsInUse, CfgW'($urandom_range(0, 63)));
      send_gaps_on   = $urandom_range(0, 2) != 0;
      recv_stalls_on = $urandom_range(0, 2) != 0;
      s = spread_e'($urandom_range(0, 2));
      if ($urandom_range(0, 3) != 0) begin
        issue_request(plain_req(KindClear));
        sent++;
      end
      // mostly small stores keep queries short; a few larger ones
      n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(1, 16);
      repeat (n_pts) begin
        issue_request(random_load(s));
        sent++;
        if ($urandom_range(0, 19) == 0) issue_request(plain_req(KindUnused));
      end
      n_q = $urandom_range(1, 8);
      repeat (n_q) begin
        if ($urandom_range(0, 19) == 0) issue_request(plain_req(KindUnused));
        issue_request(query_req(pick_query_index()));
        sent++;
        if ($urandom_range(0, 9) == 0) begin
          issue_request(random_load(s));
          sent++;
        end
      end
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_streaming();
    quiesce();
    write_setting(CfgNeighborCount, 6'd8);
    write_setting(CfgDimsInUse, 6'd2);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    issue_request(plain_req(KindClear));
    repeat (8) issue_request(random_load(SpreadWide));
    repeat (5) begin
      issue_request(query_req(pick_query_index()));
      issue_request(random_load(SpreadTight));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    req.valid       = 1'b0;
    req.kind        = KindLoad;
    req.query_index = '0;
    req.coord_0     = '0;
    req.coord_1     = '0;
    req.coord_2     = '0;
    req.coord_3     = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgNeighborCount;
    cfg_data        = '0;
    rst_n           = 1'b0;
    stored_count    = 0;
    k_setting       = NeighborCountRst;
    dims_setting    = DimsInUseRst;
    send_gaps_on    = 1'b1;
    recv_stalls_on  = 1'b1;
    hold_off_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_config_extremes();
    test_store_full();
    test_backpressure();
    test_random_sequences();
    test_streaming();
    quiesce();

    $display("covered %0d loads, %0d queries, %0d clears and %0d ignored requests",
             loads_sent, queries_sent, clears_sent, ignored_sent);
    $display("over %0d register writes; %0d results checked, %0d errors",
             settings_tried, results_checked, error_count);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
